// ===== hdl/crfr_pkg.sv =====
// shared constants, codes and types of the chunked frame reassembler
package crfr_pkg;

    localparam int STORE_DEPTH = 512;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W       = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int SAT_W       = (FILL_W > 9) ? FILL_W : 9;
    localparam int LEN_MAX     = 511;

    // result status codes
    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_NO_FRAME  = 3'd1;
    localparam logic [2:0] ST_GOOD      = 3'd2;
    localparam logic [2:0] ST_CSUM_FAIL = 3'd3;
    localparam logic [2:0] ST_DROPPED   = 3'd4;
    localparam logic [2:0] ST_LINK_DOWN = 3'd5;
    localparam logic [2:0] ST_OVERRUN   = 3'd6;

    // word classes handed from front to back
    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_IGNORE  = 3'd1;
    localparam logic [2:0] OP_RD_MEM  = 3'd2;
    localparam logic [2:0] OP_RD_LOW  = 3'd3;
    localparam logic [2:0] OP_RD_NONE = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_LINK     = 2'd0;
    localparam logic [1:0] CFG_MIN_LEN  = 2'd1;
    localparam logic [1:0] CFG_MAX_FILL = 2'd2;

    // chunk position
    localparam logic [1:0] POS_IDLE  = 2'd0;
    localparam logic [1:0] POS_FIRST = 2'd1;
    localparam logic [1:0] POS_LATER = 2'd2;

    typedef struct packed {
        logic [2:0]    kind;
        logic [7:0]    data;
        logic          first;
        logic          last;
        logic [AW-1:0] addr;
    } t_op;

    typedef struct packed {
        logic       link_en;
        logic [8:0] min_len;
        logic [8:0] max_fill;
    } t_cfg;

endpackage

// ===== hdl/crfr_front.sv =====
// front end: takes input words and classifies them for the back end
module crfr_front
    import crfr_pkg::*;
(
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_action,
    input  logic [7:0] i_data_byte,
    input  logic       i_chunk_first,
    input  logic       i_chunk_last,
    input  logic [8:0] i_read_index,
    input  logic       i_link_en,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_op        o_op
);

    logic [IDX_W-1:0] idx_ext;
    logic             in_range;
    logic             low_entry;

    assign idx_ext   = IDX_W'(i_read_index);
    assign in_range  = idx_ext < IDX_W'(STORE_DEPTH);
    // entries 0 and 1 live in flops so a preamble restart can rewrite both at once
    assign low_entry = idx_ext < IDX_W'(2);

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        o_op.data  = i_data_byte;
        o_op.first = i_chunk_first;
        o_op.last  = i_chunk_last;
        o_op.addr  = idx_ext[AW-1:0];
        if (i_action) begin
            if (!in_range) begin
                o_op.kind = OP_RD_NONE;
            end else if (low_entry) begin
                o_op.kind = OP_RD_LOW;
            end else begin
                o_op.kind = OP_RD_MEM;
            end
        end else if (i_link_en) begin
            o_op.kind = OP_PUSH;
        end else begin
            o_op.kind = OP_IGNORE;
        end
    end

endmodule

// ===== hdl/crfr_queue.sv =====
// two-entry queue between front and back end
module crfr_queue
    import crfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op
);

    t_op        r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_op    = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

endmodule

// ===== hdl/crfr_back.sv =====
// back end: chunk tracking, frame store, checksum and result register
module crfr_back
    import crfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_op        i_op,
    output logic       o_pop,
    input  t_cfg       i_cfg,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic [7:0] o_msg_type,
    output logic [8:0] o_frame_length,
    output logic [7:0] o_read_data
);

    logic [7:0]        r_mem [STORE_DEPTH];
    logic [7:0]        r_mem_q;

    logic [FILL_W-1:0] r_fill,   n_fill;
    logic [7:0]        r_sum,    n_sum;
    logic [7:0]        r_last,   n_last;
    logic [7:0]        r_second, n_second;
    logic [7:0]        r_head,   n_head;
    logic [1:0]        r_pos,    n_pos;
    logic              r_drop,   n_drop;
    logic              r_ovr,    n_ovr;
    logic [7:0]        r_ent0,   n_ent0;
    logic [7:0]        r_ent1,   n_ent1;
    logic [7:0]        r_ent4,   n_ent4;

    logic              r_out_valid;
    logic [2:0]        r_status;
    logic [7:0]        r_ftype;
    logic [8:0]        r_flen;
    logic [7:0]        r_rd;
    logic              r_rd_mem;

    logic              go;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [7:0]        mem_wd;
    logic              mem_re;
    logic [2:0]        res_status;
    logic [7:0]        res_ftype;
    logic [8:0]        res_flen;
    logic [7:0]        res_rd;
    logic              res_rd_mem;

    assign go    = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop = go;

    always_comb begin
        logic              start;
        logic              stored;
        logic [7:0]        csum;
        logic [SAT_W-1:0]  fill_w;
        n_fill     = r_fill;
        n_sum      = r_sum;
        n_last     = r_last;
        n_second   = r_second;
        n_head     = r_head;
        n_pos      = r_pos;
        n_drop     = r_drop;
        n_ovr      = r_ovr;
        n_ent0     = r_ent0;
        n_ent1     = r_ent1;
        n_ent4     = r_ent4;
        mem_we     = 1'b0;
        mem_wa     = r_fill[AW-1:0];
        mem_wd     = i_op.data;
        mem_re     = 1'b0;
        res_status = ST_BUSY;
        res_ftype  = 8'd0;
        res_flen   = 9'd0;
        res_rd     = 8'd0;
        res_rd_mem = 1'b0;
        start      = i_op.first || (r_pos == POS_IDLE);
        stored     = 1'b0;
        csum       = 8'd0;
        fill_w     = SAT_W'(r_fill);
        if (go) begin
            unique case (i_op.kind)
                OP_RD_MEM: begin
                    mem_re     = 1'b1;
                    res_rd_mem = 1'b1;
                end
                OP_RD_LOW: begin
                    res_rd = i_op.addr[0] ? r_ent1 : r_ent0;
                end
                OP_RD_NONE: begin
                    res_rd = 8'd0;
                end
                OP_IGNORE: begin
                    res_status = ST_LINK_DOWN;
                end
                OP_PUSH: begin
                    if (start) begin
                        n_drop = 1'b0;
                        n_pos  = POS_FIRST;
                        n_head = i_op.data;
                        // oversize store at chunk start: clear and drop the chunk
                        if (SAT_W'(r_fill) > SAT_W'(i_cfg.max_fill)) begin
                            n_fill   = '0;
                            n_sum    = 8'd0;
                            n_last   = 8'd0;
                            n_second = 8'd0;
                            n_ovr    = 1'b0;
                            n_drop   = 1'b1;
                        end
                    end else if (r_pos == POS_FIRST) begin
                        n_pos = POS_LATER;
                    end

                    if (n_drop) begin
                        res_status = ST_DROPPED;
                    end else begin
                        if (n_pos == POS_LATER && !i_op.first && n_head == 8'h55
                            && i_op.data == 8'hAA) begin
                            // preamble as chunk opener: frame restarts as 55 aa
                            n_head   = 8'd0;
                            n_fill   = FILL_W'(2);
                            n_sum    = 8'hFF;
                            n_second = 8'h55;
                            n_last   = 8'hAA;
                            n_ovr    = 1'b0;
                            n_ent0   = 8'h55;
                            n_ent1   = 8'hAA;
                            stored   = 1'b1;
                        end else begin
                            if (n_pos == POS_LATER) begin
                                n_head = 8'd0;
                            end
                            if (n_fill >= FILL_W'(STORE_DEPTH)) begin
                                n_ovr  = 1'b1;
                                stored = 1'b0;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = n_fill[AW-1:0];
                                if (n_fill == FILL_W'(0)) begin
                                    n_ent0 = i_op.data;
                                end
                                if (n_fill == FILL_W'(1)) begin
                                    n_ent1 = i_op.data;
                                end
                                if (n_fill == FILL_W'(4)) begin
                                    n_ent4 = i_op.data;
                                end
                                n_fill   = n_fill + FILL_W'(1);
                                n_sum    = n_sum + i_op.data;
                                n_second = n_last;
                                n_last   = i_op.data;
                                stored   = 1'b1;
                            end
                        end
                        res_status = stored ? ST_BUSY : ST_OVERRUN;

                        if (i_op.last) begin
                            fill_w = SAT_W'(n_fill);
                            csum   = n_sum - n_last - n_second;
                            if (n_ovr) begin
                                res_status = ST_OVERRUN;
                                n_fill     = '0;
                                n_sum      = 8'd0;
                                n_last     = 8'd0;
                                n_second   = 8'd0;
                                n_ovr      = 1'b0;
                            end else if (fill_w >= SAT_W'(i_cfg.min_len)
                                         && fill_w >= SAT_W'(2) && n_last == 8'hFF) begin
                                res_flen = (fill_w > SAT_W'(LEN_MAX)) ? 9'(LEN_MAX)
                                                                     : fill_w[8:0];
                                if (csum == n_second) begin
                                    res_status = ST_GOOD;
                                    res_ftype  = (fill_w >= SAT_W'(5)) ? n_ent4 : 8'd0;
                                end else begin
                                    res_status = ST_CSUM_FAIL;
                                end
                                n_fill   = '0;
                                n_sum    = 8'd0;
                                n_last   = 8'd0;
                                n_second = 8'd0;
                                n_ovr    = 1'b0;
                            end else begin
                                res_status = ST_NO_FRAME;
                            end
                        end
                    end

                    if (i_op.last) begin
                        n_pos  = POS_IDLE;
                        n_drop = 1'b0;
                    end
                end
                default: begin
                    res_status = ST_BUSY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_sum       <= 8'd0;
            r_last      <= 8'd0;
            r_second    <= 8'd0;
            r_head      <= 8'd0;
            r_pos       <= POS_IDLE;
            r_drop      <= 1'b0;
            r_ovr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_sum    <= n_sum;
            r_last   <= n_last;
            r_second <= n_second;
            r_head   <= n_head;
            r_pos    <= n_pos;
            r_drop   <= n_drop;
            r_ovr    <= n_ovr;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers and frame store
    always_ff @(posedge i_clk) begin
        r_ent0 <= n_ent0;
        r_ent1 <= n_ent1;
        r_ent4 <= n_ent4;
        if (go) begin
            r_status <= res_status;
            r_ftype  <= res_ftype;
            r_flen   <= res_flen;
            r_rd     <= res_rd;
            r_rd_mem <= res_rd_mem;
        end
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        // read data holds while the result stalls
        if (mem_re) begin
            r_mem_q <= r_mem[i_op.addr];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_msg_type     = r_ftype;
    assign o_frame_length = r_flen;
    assign o_read_data    = r_rd_mem ? r_mem_q : r_rd;

endmodule

// ===== hdl/chunked_frame_reassembler_core.sv =====
// top level of the chunked frame reassembler
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_ready      action, data_byte, chunk flags, read_index
//  result    out        o_out_valid / i_out_ready    status, msg type, frame_length, read_data
//  config    in         i_cfg_we (no wait)           i_cfg_index, i_cfg_wdata
//
// one word per cycle sustained while results are taken; a taken word goes into a queue slot,
// then the back end writes its result into the result register
// the back end executes one word per cycle from the two-entry queue; a stalled result
// holds the back end and the queue fills, then o_in_ready drops
// synchronous active-low reset; the frame store holds no reset, nothing else needs a pass
module chunked_frame_reassembler_core
    import crfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_action,
    input  logic [7:0] i_data_byte,
    input  logic       i_chunk_first,
    input  logic       i_chunk_last,
    input  logic [8:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic [7:0] o_msg_type,
    output logic [8:0] o_frame_length,
    output logic [7:0] o_read_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_wdata
);

    t_cfg r_cfg;
    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_op  op_in;
    t_op  op_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_en  <= 1'b0;
            r_cfg.min_len  <= 9'd20;
            r_cfg.max_fill <= 9'd300;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINK:     r_cfg.link_en  <= i_cfg_wdata[0];
                CFG_MIN_LEN:  r_cfg.min_len  <= i_cfg_wdata;
                CFG_MAX_FILL: r_cfg.max_fill <= i_cfg_wdata;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    crfr_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_data_byte   (i_data_byte),
        .i_chunk_first (i_chunk_first),
        .i_chunk_last  (i_chunk_last),
        .i_read_index  (i_read_index),
        .i_link_en     (r_cfg.link_en),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_op          (op_in)
    );

    crfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (op_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (op_out)
    );

    crfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_op           (op_out),
        .o_pop          (q_pop),
        .i_cfg          (r_cfg),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_msg_type     (o_msg_type),
        .o_frame_length (o_frame_length),
        .o_read_data    (o_read_data)
    );

endmodule

// ===== hdl/crfr_checker.sv =====
// port-level checks for the chunked frame reassembler, bound to the top level
module crfr_checker
    import crfr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_status,
    input logic [7:0] o_msg_type,
    input logic [8:0] o_frame_length,
    input logic [7:0] o_read_data
);

    // a stalled result holds its word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
        && $stable(o_msg_type) && $stable(o_frame_length) && $stable(o_read_data))
        else $error("result changed while stalled");

    a_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_GOOD |-> o_msg_type == 8'd0)
        else $error("frame type without good frame");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_GOOD && o_status != ST_CSUM_FAIL
        |-> o_frame_length == 9'd0)
        else $error("frame length without finished frame");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind chunked_frame_reassembler_core crfr_checker u_crfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_msg_type     (o_msg_type),
    .o_frame_length (o_frame_length),
    .o_read_data    (o_read_data)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the chunked frame reassembler core
module testbench;
    import crfr_pkg::*;

    localparam logic ACT_PUSH    = 1'b0;
    localparam logic ACT_READ    = 1'b1;
    localparam int   DRAIN_LIMIT = 20000;
    localparam int   STALL_LEN   = 120;
    localparam int   SHOW_MAX    = 10;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] msg_type;
        logic [8:0] frame_length;
        logic [7:0] read_data;
    } t_exp_result;

    // tracks the frame store and chunk state, queues the result each word should give
    class frame_scoreboard;
        logic [7:0]        store [STORE_DEPTH];
        logic [FILL_W-1:0] fill;
        logic [7:0]        byte_total;
        logic [7:0]        last_b;
        logic [7:0]        prev_b;
        logic [7:0]        head_b;
        logic [1:0]        pos;
        bit                dropping;
        bit                overrun;
        bit                link_en;
        logic [8:0]        min_len;
        logic [8:0]        max_fill;
        int                written_top;
        int                mismatches;
        t_exp_result       expected_q [$];

        function new();
            clear_fill();
            head_b      = '0;
            pos         = POS_IDLE;
            dropping    = 1'b0;
            link_en     = 1'b0;
            min_len     = 9'd20;
            max_fill    = 9'd300;
            written_top = 0;
            mismatches  = 0;
        endfunction

        function void clear_fill();
            fill       = '0;
            byte_total = '0;
            last_b     = '0;
            prev_b     = '0;
            overrun    = 1'b0;
        endfunction

        function bit store_byte(logic [7:0] b);
            if (fill >= FILL_W'(STORE_DEPTH)) begin
                overrun = 1'b1;
                return 1'b0;
            end
            store[fill[AW-1:0]] = b;
            fill        = fill + FILL_W'(1);
            byte_total  = byte_total + b;
            prev_b      = last_b;
            last_b      = b;
            // entries are always written as a prefix of the store
            if (int'(fill) > written_top) written_top = int'(fill);
            return 1'b1;
        endfunction

        function void set_reg(logic [1:0] index, logic [8:0] value);
            case (index)
                CFG_LINK:     link_en  = value[0];
                CFG_MIN_LEN:  min_len  = value;
                CFG_MAX_FILL: max_fill = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(logic action, logic [7:0] data, logic first, logic last,
                                logic [8:0] idx);
            t_exp_result   r;
            bit            kept;
            logic [7:0]    body_sum;
            r = '0;
            if (action == ACT_READ) begin
                r.read_data = (int'(idx) < STORE_DEPTH) ? store[idx] : 8'h00;
            end else if (!link_en) begin
                r.status = ST_LINK_DOWN;
            end else begin
                if (first || pos == POS_IDLE) begin
                    dropping = 1'b0;
                    pos      = POS_FIRST;
                    head_b   = data;
                    if (fill > FILL_W'(max_fill)) begin
                        clear_fill();
                        dropping = 1'b1;
                    end
                end else if (pos == POS_FIRST) begin
                    pos = POS_LATER;
                end

                if (dropping) begin
                    r.status = ST_DROPPED;
                end else begin
                    if (pos == POS_LATER && head_b == 8'h55 && data == 8'hAA && !first) begin
                        // preamble completed by the second word of a chunk
                        head_b = '0;
                        clear_fill();
                        void'(store_byte(8'h55));
                        kept = store_byte(8'hAA);
                    end else begin
                        if (pos == POS_LATER) head_b = '0;
                        kept = store_byte(data);
                    end
                    r.status = kept ? ST_BUSY : ST_OVERRUN;

                    if (last) begin
                        if (overrun) begin
                            r.status = ST_OVERRUN;
                            clear_fill();
                        end else if (fill >= FILL_W'(min_len) && fill >= FILL_W'(2)
                                     && last_b == 8'hFF) begin
                            body_sum       = byte_total - last_b - prev_b;
                            r.frame_length = (fill > FILL_W'(LEN_MAX)) ? 9'(LEN_MAX)
                                                                       : fill[8:0];
                            if (body_sum == prev_b) begin
                                r.status = ST_GOOD;
                                if (fill >= FILL_W'(5)) r.msg_type = store[4];
                            end else begin
                                r.status = ST_CSUM_FAIL;
                            end
                            clear_fill();
                        end else begin
                            r.status = ST_NO_FRAME;
                        end
                    end
                end

                if (last) begin
                    pos      = POS_IDLE;
                    dropping = 1'b0;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [2:0] status, logic [7:0] msg_type,
                                   logic [8:0] frame_length, logic [7:0] read_data);
            t_exp_result got;
            t_exp_result exp;
            got = {status, msg_type, frame_length, read_data};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result: status %0d type %h len %0d data %h",
                             got.status, got.msg_type, got.frame_length, got.read_data);
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status || got.msg_type !== exp.msg_type ||
                got.frame_length !== exp.frame_length || got.read_data !== exp.read_data) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("mismatch: exp %0d %h %0d %h, got %0d %h %0d %h",
                             exp.status, exp.msg_type, exp.frame_length, exp.read_data,
                             got.status, got.msg_type, got.frame_length, got.read_data);
            end
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_ready;
    logic       i_action       = 1'b0;
    logic [7:0] i_data_byte    = '0;
    logic       i_chunk_first  = 1'b0;
    logic       i_chunk_last   = 1'b0;
    logic [8:0] i_read_index   = '0;
    logic       o_out_valid;
    logic       i_out_ready    = 1'b0;
    logic [2:0] o_status;
    logic [7:0] o_msg_type;
    logic [8:0] o_frame_length;
    logic [7:0] o_read_data;
    logic       i_cfg_we       = 1'b0;
    logic [1:0] i_cfg_index    = CFG_LINK;
    logic [8:0] i_cfg_wdata    = '0;

    frame_scoreboard sb;
    int send_idle_pct = 27;
    int recv_idle_pct = 80;
    int items_sent    = 0;
    bit stall_request = 1'b0;

    chunked_frame_reassembler_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .i_chunk_first  (i_chunk_first),
        .i_chunk_last   (i_chunk_last),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_msg_type     (o_msg_type),
        .o_frame_length (o_frame_length),
        .o_read_data    (o_read_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver side, with one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (STALL_LEN) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_msg_type, o_frame_length, o_read_data);
    end

    task automatic send_word(logic action, logic [7:0] data, logic first, logic last,
                             logic [8:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= action;
        i_data_byte   <= data;
        i_chunk_first <= first;
        i_chunk_last  <= last;
        i_read_index  <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(action, data, first, last, idx);
        items_sent++;
    endtask

    // reads only ever target entries that have been written
    task automatic send_read();
        int         top;
        logic [8:0] idx;
        top = sb.written_top;
        case ($urandom_range(0, 3))
            0: idx = '0;
            1: idx = 9'(top - 1);
            default: idx = 9'($urandom_range(0, top - 1));
        endcase
        send_word(ACT_READ, 8'($urandom), 1'($urandom), 1'($urandom), idx);
    endtask

    task automatic send_frame(int len, bit bad, bit trunc, int split_pct);
        logic [7:0] bytes [$];
        logic [7:0] csum;
        logic [7:0] b;
        bit         at_start;
        bit         close;
        bytes.push_back(8'h55);
        bytes.push_back(8'hAA);
        csum = 8'h55 + 8'hAA;
        for (int i = 2; i < len - 2; i++) begin
            b = 8'($urandom);
            bytes.push_back(b);
            csum = csum + b;
        end
        bytes.push_back(bad ? csum ^ 8'(1 << $urandom_range(0, 7)) : csum);
        // a truncated frame loses its closing 0xff
        if (!trunc) bytes.push_back(8'hFF);
        at_start = 1'b1;
        foreach (bytes[i]) begin
            close = (i == bytes.size() - 1) || ($urandom_range(0, 99) < split_pct);
            if (sb.written_top > 0 && $urandom_range(0, 99) < 6) send_read();
            // the first flag is sometimes left off a chunk opening word
            send_word(ACT_PUSH, bytes[i], at_start && ($urandom_range(0, 9) != 0), close,
                      9'($urandom));
            at_start = close;
        end
    endtask

    task automatic run_traffic(int n_items, int max_len);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 75) begin
                send_frame($urandom_range(4, max_len), $urandom_range(0, 9) == 0,
                           $urandom_range(0, 9) == 0, 15);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if (sb.written_top > 0 && $urandom_range(0, 2) == 0)
                        send_read();
                    else
                        send_word(ACT_PUSH, 8'($urandom), 1'($urandom), 1'($urandom),
                                  9'($urandom));
                end
            end
        end
    endtask

    task automatic drain(int limit);
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [8:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_reg(index, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // link is down after reset
        send_word(ACT_PUSH, 8'hFF, 1'b1, 1'b1, 9'h000);
        send_word(ACT_PUSH, 8'h00, 1'b0, 1'b0, 9'h1FF);
        drain(DRAIN_LIMIT);
        write_reg(CFG_LINK, 9'd1);
        write_reg(CFG_MIN_LEN, 9'd3);
        write_reg(CFG_MAX_FILL, 9'd300);

        // good frame in one chunk, type byte 0xff
        send_word(ACT_PUSH, 8'h55, 1'b1, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'hAA, 1'b0, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'h00, 1'b0, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'h80, 1'b0, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'hFF, 1'b0, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'h7E, 1'b0, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'hFF, 1'b0, 1'b1, 9'h000);
        // bad checksum over two chunks, the second opens without its first flag
        send_word(ACT_PUSH, 8'h55, 1'b1, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'hAA, 1'b0, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'h12, 1'b0, 1'b1, 9'h000);
        send_word(ACT_PUSH, 8'h34, 1'b0, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'h56, 1'b0, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'h00, 1'b0, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'hFF, 1'b0, 1'b1, 9'h000);
        send_word(ACT_READ, 8'h00, 1'b0, 1'b0, 9'd0);
        send_word(ACT_READ, 8'hFF, 1'b1, 1'b1, 9'd4);
        send_word(ACT_READ, 8'h00, 1'b0, 1'b0, 9'd6);
        // first flag inside a chunk splits the preamble, no restart
        send_word(ACT_PUSH, 8'h55, 1'b1, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'hAA, 1'b1, 1'b1, 9'h000);
        // preamble deeper in a chunk is plain data
        send_word(ACT_PUSH, 8'h01, 1'b1, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'h55, 1'b0, 1'b0, 9'h000);
        send_word(ACT_PUSH, 8'hAA, 1'b0, 1'b1, 9'h000);

        drain(DRAIN_LIMIT);
        write_reg(CFG_MIN_LEN, 9'($urandom_range(3, 12)));
        run_traffic(60, 24);

        drain(DRAIN_LIMIT);
        send_idle_pct = 80;
        recv_idle_pct = 27;
        write_reg(CFG_MIN_LEN, 9'd3);
        write_reg(CFG_MAX_FILL, 9'd1);
        run_traffic(60, 16);
        drain(DRAIN_LIMIT);
        write_reg(CFG_LINK, 9'd0);
        run_traffic(10, 8);
        drain(DRAIN_LIMIT);
        write_reg(CFG_LINK, 9'd1);

        drain(DRAIN_LIMIT);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_MIN_LEN, 9'd511);
        write_reg(CFG_MAX_FILL, 9'd511);
        stall_request = 1'b1;
        run_traffic(30, 16);
        // one frame that runs past the store
        send_frame(516, 1'b0, 1'b0, 0);
        drain(DRAIN_LIMIT);
        write_reg(CFG_MIN_LEN, 9'd20);
        write_reg(CFG_MAX_FILL, 9'd300);
        run_traffic(30, 40);

        drain(DRAIN_LIMIT);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/crfr_pkg.sv
hdl/crfr_front.sv
hdl/crfr_queue.sv
hdl/crfr_back.sv
hdl/chunked_frame_reassembler_core.sv
hdl/crfr_checker.sv
tb/testbench.sv
